// ===== rtl/core/pida_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional insert/delete array: shared definitions
// Item types, operation and status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package pida_pkg;

    localparam int PIDA_DEPTH = 64;
    localparam int DATA_W     = 32;
    localparam int POS_W      = 6;
    localparam int COUNT_W    = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_RD_WAIT,
        SQ_DEL_HEAD,
        SQ_DEL_MOVE,
        SQ_INS_MOVE,
        SQ_INS_PUT,
        SQ_FINISH
    } seq_state_t;

    typedef struct packed {
        logic [1:0]               operation;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [COUNT_W-1:0]       count;
        logic [1:0]               status;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/pida_ram.sv =====
// ----------------------------------------------------------------------------
// Positional insert/delete array: entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pida_ram
    import pida_pkg::*;
#(
    parameter int DEPTH = PIDA_DEPTH,
    parameter int AW    = 6
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [AW-1:0]     raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/positional_insert_delete_array.sv =====
// ----------------------------------------------------------------------------
// Positional insert/delete array
// Ordered store of signed words with insert, delete and read at a position.
// ----------------------------------------------------------------------------
// An insert shifts count - position entries up before it writes the new word;
// a delete shifts the count - position - 1 entries above it down by one.
// A rejected item goes straight to the result. One item is in work at a time;
// the shift moves one entry per cycle through the one read and one write port.
// Reset clears the entry count and the sequencer; the memory is not cleared.
`default_nettype none

module positional_insert_delete_array
    import pida_pkg::*;
#(
    parameter int DEPTH = PIDA_DEPTH
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    seq_state_t        state_reg, state_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [DATA_W-1:0] res_value_reg, res_value_next;
    status_t           res_status_reg, res_status_next;
    logic [CW-1:0]     res_count_reg, res_count_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic [PW-1:0]     pos_in;
    logic [CW-1:0]     pos_inc;
    logic [CW-1:0]     ptr_inc;

    assign s_ready = (state_reg == SQ_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign pos_in  = PW'(s_data.position);
    assign pos_inc = CW'(pos_reg) + CW'(1);
    assign ptr_inc = CW'(ptr_reg) + CW'(1);

    pida_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SQ_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        ptr_reg        <= ptr_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
        m_data_reg     <= m_data_next;
    end

    always_comb begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        ptr_next        = ptr_reg;
        count_next      = count_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = '0;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            SQ_IDLE: begin
                if (s_valid) begin
                    pos_next        = pos_in;
                    val_next        = s_data.value;
                    res_value_next  = '0;
                    res_status_next = ST_OK;
                    res_count_next  = count_reg;
                    state_next      = SQ_FINISH;
                    case (s_data.operation)
                        OP_INSERT: begin
                            if (count_reg == CW'(DEPTH)) begin
                                res_status_next = ST_FULL;
                            end else if (pos_in > PW'(count_reg)) begin
                                res_status_next = ST_RANGE;
                            end else begin
                                res_count_next = count_reg + CW'(1);
                                if (pos_in == PW'(count_reg)) begin
                                    state_next = SQ_INS_PUT;
                                end else begin
                                    ram_raddr  = AW'(count_reg - CW'(1));
                                    ptr_next   = AW'(count_reg - CW'(1));
                                    state_next = SQ_INS_MOVE;
                                end
                            end
                        end
                        OP_DELETE: begin
                            if (pos_in >= PW'(count_reg)) begin
                                res_status_next = ST_RANGE;
                            end else begin
                                res_count_next = count_reg - CW'(1);
                                ram_raddr      = pos_in[AW-1:0];
                                state_next     = SQ_DEL_HEAD;
                            end
                        end
                        OP_READ: begin
                            if (pos_in >= PW'(count_reg)) begin
                                res_status_next = ST_RANGE;
                            end else begin
                                ram_raddr  = pos_in[AW-1:0];
                                state_next = SQ_RD_WAIT;
                            end
                        end
                        default: begin
                            state_next = SQ_FINISH;
                        end
                    endcase
                end
            end
            SQ_RD_WAIT: begin
                res_value_next = ram_rdata;
                state_next     = SQ_FINISH;
            end
            SQ_DEL_HEAD: begin
                res_value_next = ram_rdata;
                if (pos_inc < count_reg) begin
                    ram_raddr  = AW'(pos_inc);
                    ptr_next   = AW'(pos_inc);
                    state_next = SQ_DEL_MOVE;
                end else begin
                    state_next = SQ_FINISH;
                end
            end
            SQ_DEL_MOVE: begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg - AW'(1);
                ram_wdata = ram_rdata;
                if (ptr_inc < count_reg) begin
                    ram_raddr = AW'(ptr_inc);
                    ptr_next  = AW'(ptr_inc);
                end else begin
                    state_next = SQ_FINISH;
                end
            end
            SQ_INS_MOVE: begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg + AW'(1);
                ram_wdata = ram_rdata;
                if (CW'(ptr_reg) > CW'(pos_reg)) begin
                    ram_raddr = ptr_reg - AW'(1);
                    ptr_next  = ptr_reg - AW'(1);
                end else begin
                    state_next = SQ_INS_PUT;
                end
            end
            SQ_INS_PUT: begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[AW-1:0];
                ram_wdata  = val_reg;
                state_next = SQ_FINISH;
            end
            SQ_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.read_value = res_value_reg;
                    m_data_next.count      = COUNT_W'(res_count_reg);
                    m_data_next.status     = res_status_reg;
                    count_next             = res_count_reg;
                    state_next             = SQ_IDLE;
                end
            end
            default: begin
                state_next = SQ_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/pida_checker.sv =====
// ----------------------------------------------------------------------------
// Positional insert/delete array: port checker
// Watches the item ports of the top level over time and flags violations.
// ----------------------------------------------------------------------------
`default_nettype none

module pida_checker
    import pida_pkg::*;
#(
    parameter int DEPTH = PIDA_DEPTH
) (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_item_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    logic unused_ok;

    assign unused_ok = ^s_data;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result item changed or dropped while stalled.");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Input accepted again before the previous item finished.");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_data.count) <= DEPTH)
        else $error("Reported count exceeds the store depth.");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_FULL |-> 32'(m_data.count) == DEPTH)
        else $error("Full status reported with a store that is not full.");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.read_value == '0)
        else $error("Rejected item carries a non-zero value.");

endmodule

bind positional_insert_delete_array pida_checker #(
    .DEPTH (DEPTH)
) u_pida_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ===== tb/positional_insert_delete_array_tb.sv =====
// ----------------------------------------------------------------------------
// Positional insert/delete array: self-checking testbench
// This bench first sends a short directed table, then random insert, delete
// and read items that fill the store to full and drain it to empty.
// Each result is compared against the table's fixed result or an in-bench
// shadow of the ordered store, under three sender and receiver idle mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_insert_delete_array_tb;

    import pida_pkg::*;

    localparam int STORE_DEPTH     = PIDA_DEPTH;
    localparam int ITEMS_PER_PHASE = 630;
    localparam int STALL_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = STORE_DEPTH + 8;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    typedef struct {
        in_item_t  item;
        bit        fixed;
        out_item_t result;
    } directed_row_t;

    logic signed [DATA_W-1:0] shadow_entries [STORE_DEPTH];
    int                       shadow_count = 0;
    out_item_t                pending_results [$];
    directed_row_t            directed_rows [$];

    int errors        = 0;
    int items_sent    = 0;
    int full_rejects  = 0;
    int range_rejects = 0;
    int peak_count    = 0;
    int stall_cycles  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit filling       = 1'b1;

    positional_insert_delete_array u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic out_item_t apply_item(in_item_t it);
        out_item_t r;
        r.read_value = '0;
        r.status     = ST_OK;
        case (op_t'(it.operation))
            OP_INSERT: begin
                if (shadow_count >= STORE_DEPTH) begin
                    r.status = ST_FULL;
                end else if (it.position > shadow_count) begin
                    r.status = ST_RANGE;
                end else begin
                    for (int i = shadow_count; i > it.position; i--) begin
                        shadow_entries[i] = shadow_entries[i-1];
                    end
                    shadow_entries[it.position] = it.value;
                    shadow_count++;
                end
            end
            OP_DELETE: begin
                if (it.position >= shadow_count) begin
                    r.status = ST_RANGE;
                end else begin
                    r.read_value = shadow_entries[it.position];
                    for (int i = it.position + 1; i < shadow_count; i++) begin
                        shadow_entries[i-1] = shadow_entries[i];
                    end
                    shadow_count--;
                end
            end
            OP_READ: begin
                if (it.position >= shadow_count) begin
                    r.status = ST_RANGE;
                end else begin
                    r.read_value = shadow_entries[it.position];
                end
            end
            default: begin
            end
        endcase
        r.count = shadow_count[COUNT_W-1:0];
        if (r.status == ST_FULL) full_rejects++;
        if (r.status == ST_RANGE) range_rejects++;
        if (shadow_count > peak_count) peak_count = shadow_count;
        return r;
    endfunction

    // The store swings between filling and draining so that both the full
    // and the empty ends are reached many times.
    function automatic in_item_t random_item();
        in_item_t it;
        op_t      op;
        int       pick;
        if (shadow_count == 0) begin
            filling = 1'b1;
        end else if (shadow_count == STORE_DEPTH && $urandom_range(3) == 0) begin
            filling = 1'b0;
        end
        pick = $urandom_range(99);
        if (pick < 15) begin
            op = OP_READ;
        end else if ((pick < 85) == filling) begin
            op = OP_INSERT;
        end else begin
            op = OP_DELETE;
        end
        it.operation = op;
        case ($urandom_range(7))
            0:       it.value = 32'h7FFF_FFFF;
            1:       it.value = 32'h8000_0000;
            2:       it.value = '0;
            3:       it.value = '1;
            default: it.value = $urandom;
        endcase
        it.position = POS_W'($urandom_range(STORE_DEPTH - 1));
        if ($urandom_range(9) != 0) begin
            if (op == OP_INSERT && shadow_count < STORE_DEPTH) begin
                it.position = POS_W'($urandom_range(shadow_count));
            end else if (op != OP_INSERT && shadow_count > 0) begin
                it.position = POS_W'($urandom_range(shadow_count - 1));
            end
        end
        return it;
    endfunction

    task automatic add_row(op_t op, int pos, logic [DATA_W-1:0] val, bit fixed,
                           logic [DATA_W-1:0] exp_val, int exp_count,
                           status_t exp_status);
        directed_row_t row;
        row.item.operation   = op;
        row.item.position    = pos[POS_W-1:0];
        row.item.value       = val;
        row.fixed            = fixed;
        row.result.read_value = exp_val;
        row.result.count     = exp_count[COUNT_W-1:0];
        row.result.status    = exp_status;
        directed_rows.push_back(row);
    endtask

    task automatic send_item(in_item_t it, bit fixed, out_item_t fixed_result);
        out_item_t predicted;
        int        gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_item(it);
        pending_results.push_back(fixed ? fixed_result : predicted);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("[%0t] mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("item with nothing expected", m_data.read_value, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_data.read_value !== want.read_value)
                    report_mismatch("read_value", m_data.read_value, want.read_value);
                if (m_data.count !== want.count)
                    report_mismatch("count", DATA_W'(m_data.count), DATA_W'(want.count));
                if (m_data.status !== want.status)
                    report_mismatch("status", DATA_W'(m_data.status),
                                    DATA_W'(want.status));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles.", STALL_LIMIT);
                $display("positional_insert_delete_array_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        out_item_t no_result;
        no_result = '0;

        add_row(OP_READ,    0, 32'h0000_0000, 1, 32'h0000_0000, 0, ST_RANGE);
        add_row(OP_DELETE,  0, 32'h0000_0000, 1, 32'h0000_0000, 0, ST_RANGE);
        add_row(OP_INSERT,  1, 32'h0000_0001, 1, 32'h0000_0000, 0, ST_RANGE);
        add_row(OP_INSERT,  0, 32'h7FFF_FFFF, 1, 32'h0000_0000, 1, ST_OK);
        add_row(OP_INSERT,  1, 32'h8000_0000, 1, 32'h0000_0000, 2, ST_OK);
        add_row(OP_INSERT,  0, 32'hFFFF_FFFF, 1, 32'h0000_0000, 3, ST_OK);
        add_row(OP_INSERT,  1, 32'h0000_0000, 1, 32'h0000_0000, 4, ST_OK);
        add_row(OP_READ,    0, 32'h1234_5678, 1, 32'hFFFF_FFFF, 4, ST_OK);
        add_row(OP_READ,    3, 32'h0000_0000, 1, 32'h8000_0000, 4, ST_OK);
        add_row(OP_READ,    4, 32'h0000_0000, 1, 32'h0000_0000, 4, ST_RANGE);
        add_row(OP_READ,   63, 32'hFFFF_FFFF, 1, 32'h0000_0000, 4, ST_RANGE);
        add_row(OP_INSERT, 63, 32'hDEAD_BEEF, 1, 32'h0000_0000, 4, ST_RANGE);
        add_row(OP_DELETE, 63, 32'h0000_0000, 1, 32'h0000_0000, 4, ST_RANGE);
        add_row(OP_UNUSED,  1, 32'h1234_5678, 1, 32'h0000_0000, 4, ST_OK);
        add_row(OP_INSERT,  4, 32'h5555_5555, 0, '0, 0, ST_OK);
        add_row(OP_DELETE,  0, 32'h0000_0000, 1, 32'hFFFF_FFFF, 4, ST_OK);
        add_row(OP_DELETE,  3, 32'h0000_0000, 0, '0, 0, ST_OK);
        add_row(OP_DELETE,  3, 32'h0000_0000, 1, 32'h0000_0000, 3, ST_RANGE);
        add_row(OP_READ,    1, 32'h0000_0000, 0, '0, 0, ST_OK);
        add_row(OP_INSERT,  2, 32'hAAAA_AAAA, 0, '0, 0, ST_OK);
        add_row(OP_READ,    2, 32'h0000_0000, 0, '0, 0, ST_OK);

        send_idle_pct = 12;
        recv_idle_pct = 82;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item, directed_rows[i].fixed,
                      directed_rows[i].result);
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 12;
                    recv_idle_pct = 82;
                end
                1: begin
                    send_idle_pct = 82;
                    recv_idle_pct = 12;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (ITEMS_PER_PHASE) send_item(random_item(), 1'b0, no_result);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d items (%0d directed) over three idle mixes; peak count %0d.",
                 items_sent, directed_rows.size(), peak_count);
        $display("Rejections seen: %0d on a full store, %0d for position out of range.",
                 full_rejects, range_rejects);
        if (errors == 0) begin
            $display("positional_insert_delete_array_tb: PASS");
        end else begin
            $display("positional_insert_delete_array_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== positional_insert_delete_array.f =====
rtl/core/pida_pkg.sv
rtl/core/pida_ram.sv
rtl/core/positional_insert_delete_array.sv
rtl/core/pida_checker.sv
tb/positional_insert_delete_array_tb.sv
